@@ sv/nsa_pkg.sv @@
package nsa_pkg;

    localparam int MaxInputs = 64;
    localparam int SumW      = 22;
    localparam int ProdW     = 38;
    localparam int CntW      = 7;

    localparam logic [2:0] KindSigmoid = 3'd0;
    localparam logic [2:0] KindTanh    = 3'd1;
    localparam logic [2:0] KindHardLim = 3'd2;
    localparam logic [2:0] KindSymLim  = 3'd3;
    localparam logic [2:0] KindSoftsgn = 3'd4;
    localparam logic [2:0] KindRelu    = 3'd5;

    localparam logic [1:0] CfgKind  = 2'd0;
    localparam logic [1:0] CfgGain  = 2'd1;
    localparam logic [1:0] CfgCount = 2'd2;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_MULT,
        ST_ROUND,
        ST_DIV,
        ST_FINISH,
        ST_OUT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accum;
        logic clear;
        logic mult;
        logic round;
        logic div_start;
        logic div_step;
        logic finish;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic group_done;
        logic is_softsign;
        logic div_last;
    } stat_t;

    // Sigmoid on [0,8] in 0.25 steps, Q0.16
    function automatic logic [15:0] sig_tab(input logic [5:0] i);
        logic [15:0] r;
        begin
            case (i)
                6'd0:  r = 16'd32768; 6'd1:  r = 16'd36843; 6'd2:  r = 16'd40793;
                6'd3:  r = 16'd44511; 6'd4:  r = 16'd47911; 6'd5:  r = 16'd50941;
                6'd6:  r = 16'd53581; 6'd7:  r = 16'd55834; 6'd8:  r = 16'd57724;
                6'd9:  r = 16'd59287; 6'd10: r = 16'd60565; 6'd11: r = 16'd61598;
                6'd12: r = 16'd62428; 6'd13: r = 16'd63090; 6'd14: r = 16'd63615;
                6'd15: r = 16'd64030; 6'd16: r = 16'd64357; 6'd17: r = 16'd64614;
                6'd18: r = 16'd64816; 6'd19: r = 16'd64974; 6'd20: r = 16'd65097;
                6'd21: r = 16'd65194; 6'd22: r = 16'd65269; 6'd23: r = 16'd65328;
                6'd24: r = 16'd65374; 6'd25: r = 16'd65410; 6'd26: r = 16'd65438;
                6'd27: r = 16'd65459; 6'd28: r = 16'd65476; 6'd29: r = 16'd65489;
                6'd30: r = 16'd65500; 6'd31: r = 16'd65508;
                default: r = 16'd65514;
            endcase
            return r;
        end
    endfunction

endpackage

@@ sv/nsa_ctrl.sv @@
module nsa_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  nsa_pkg::stat_t  stat,
    output nsa_pkg::cmd_t   cmd
);

    nsa_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nsa_pkg::ST_ACCUM;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nsa_pkg::ST_ACCUM: begin
                if (s_valid && stat.group_done) state_next = nsa_pkg::ST_MULT;
            end
            nsa_pkg::ST_MULT:  state_next = nsa_pkg::ST_ROUND;
            nsa_pkg::ST_ROUND: begin
                state_next = stat.is_softsign ? nsa_pkg::ST_DIV : nsa_pkg::ST_FINISH;
            end
            nsa_pkg::ST_DIV: begin
                if (stat.div_last) state_next = nsa_pkg::ST_FINISH;
            end
            nsa_pkg::ST_FINISH: state_next = nsa_pkg::ST_OUT;
            nsa_pkg::ST_OUT: begin
                if (m_ready) state_next = nsa_pkg::ST_ACCUM;
            end
            default: state_next = nsa_pkg::ST_ACCUM;
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            nsa_pkg::ST_ACCUM: begin
                s_ready   = 1'b1;
                cmd.accum = s_valid;
            end
            nsa_pkg::ST_MULT:   cmd.mult = 1'b1;
            nsa_pkg::ST_ROUND: begin
                cmd.round     = 1'b1;
                cmd.div_start = stat.is_softsign;
            end
            nsa_pkg::ST_DIV:    cmd.div_step = 1'b1;
            nsa_pkg::ST_FINISH: cmd.finish = 1'b1;
            nsa_pkg::ST_OUT: begin
                m_valid   = 1'b1;
                cmd.clear = m_ready;
            end
            default: ;
        endcase
    end

endmodule

@@ sv/nsa_datapath.sv @@
module nsa_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic signed [15:0] s_sample,
    input  nsa_pkg::cmd_t      cmd,
    output nsa_pkg::stat_t     stat,
    output logic signed [15:0] m_activation_value,
    output logic               m_saturated
);

    localparam int SW = nsa_pkg::SumW;
    localparam int PW = nsa_pkg::ProdW;

    logic [2:0]          kind_reg;
    logic signed [15:0]  gain_reg;
    logic [6:0]          count_reg;
    logic signed [SW-1:0] sum_reg;
    logic [6:0]          seen_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-13:0] x_reg;
    logic [PW-13:0]      a_reg;
    logic                neg_reg;
    logic signed [15:0]  val_reg;
    logic                sat_reg;
    logic [33:0]         rem_reg;
    logic [8:0]          quot_reg;
    logic [33:0]         den_reg;
    logic [3:0]          dcnt_reg;

    logic [6:0]          eff;
    logic [6:0]          seen_next;
    logic signed [SW-1:0] sum_next;
    logic signed [PW-12:0] x_full;
    logic [PW-13:0]      x_abs;
    logic [24:0]         den_w;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg  <= nsa_pkg::KindSigmoid;
            gain_reg  <= 16'sd4096;
            count_reg <= 7'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                nsa_pkg::CfgKind:  kind_reg  <= cfg_data[2:0];
                nsa_pkg::CfgGain:  gain_reg  <= cfg_data;
                nsa_pkg::CfgCount: count_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Effective group size
    always_comb begin
        eff = count_reg;
        if (eff == 7'd0) eff = 7'd1;
        if (eff > 7'(nsa_pkg::MaxInputs)) eff = 7'(nsa_pkg::MaxInputs);
    end

    assign sum_next  = sum_reg + SW'(s_sample);
    assign seen_next = seen_reg + 7'd1;
    assign stat.group_done  = (seen_next >= eff);
    assign stat.is_softsign = (kind_reg == nsa_pkg::KindSoftsgn);
    assign stat.div_last    = (dcnt_reg == 4'd0);

    // Accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            seen_reg <= '0;
        end else if (cmd.clear) begin
            sum_reg  <= '0;
            seen_reg <= '0;
        end else if (cmd.accum) begin
            sum_reg  <= sum_next;
            seen_reg <= seen_next;
        end
    end

    // Round half up: floor((p + 2048) / 4096)
    assign x_full = (PW-11)'((prod_reg + PW'(2048)) >>> 12);
    assign x_abs  = (x_full < 0) ? (PW-12)'(-x_full) : (PW-12)'(x_full);
    assign den_w  = 25'd256 + 25'(x_abs);

    // Sigmoid and tanh lookup
    logic [12:0] sarg;
    logic [15:0] t0, t1, sval;
    logic signed [17:0] tdiff;
    logic signed [24:0] tprod;
    logic [16:0] s_adj;
    logic signed [18:0] u;
    logic [9:0]  sig_o;
    logic [9:0]  tanh_o;

    always_comb begin
        t0    = '0;
        t1    = '0;
        tdiff = '0;
        tprod = '0;
        if (kind_reg == nsa_pkg::KindTanh) begin
            sarg = (a_reg > (PW-12)'(2048)) ? 13'd4096 : {a_reg[11:0], 1'b0};
        end else begin
            sarg = (a_reg >= (PW-12)'(2048)) ? 13'd2048 : a_reg[12:0];
        end
        if (sarg >= 13'd2048) begin
            sval = nsa_pkg::sig_tab(6'd32);
        end else begin
            t0    = nsa_pkg::sig_tab(sarg[11:6]);
            t1    = nsa_pkg::sig_tab(sarg[11:6] + 6'd1);
            tdiff = 18'(t1) - 18'(t0);
            tprod = 25'(tdiff) * 25'(sarg[5:0]) + 25'sd32;
            sval  = t0 + 16'(tprod >>> 6);
        end
        s_adj  = neg_reg ? (17'd65536 - 17'(sval)) : 17'(sval);
        sig_o  = 10'((s_adj + 17'd128) >> 8);
        u      = 19'(2 * 19'(sval)) - 19'sd65536;
        tanh_o = 10'((u + 19'sd128) >>> 8);
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (cmd.mult) begin
            prod_reg <= PW'(sum_reg) * PW'(gain_reg);
        end
        if (cmd.round) begin
            x_reg   <= x_full[PW-12:0] == x_full ? x_full[PW-13:0] : x_full[PW-13:0];
            neg_reg <= x_full < 0;
            a_reg   <= x_abs;
        end
        if (cmd.div_start) begin
            // numerator 256*a + den/2; divisor starts shifted up by 8
            den_reg  <= {1'b0, den_w, 8'd0};
            rem_reg  <= {x_abs, 8'd0} + 34'(den_w >> 1);
            quot_reg <= '0;
            dcnt_reg <= 4'd8;
        end else if (cmd.div_step) begin
            // one restoring step, quotient bit dcnt_reg
            if (rem_reg >= den_reg) begin
                rem_reg  <= rem_reg - den_reg;
                quot_reg <= {quot_reg[7:0], 1'b1};
            end else begin
                quot_reg <= {quot_reg[7:0], 1'b0};
            end
            den_reg  <= den_reg >> 1;
            dcnt_reg <= dcnt_reg - 4'd1;
        end
        if (cmd.finish) begin
            sat_reg <= 1'b0;
            case (kind_reg)
                nsa_pkg::KindSigmoid: val_reg <= 16'(sig_o);
                nsa_pkg::KindTanh:
                    val_reg <= neg_reg ? -16'(tanh_o) : 16'(tanh_o);
                nsa_pkg::KindHardLim:
                    val_reg <= (!neg_reg && a_reg != '0) ? 16'sd256 : 16'sd0;
                nsa_pkg::KindSymLim:
                    val_reg <= (!neg_reg && a_reg != '0) ? 16'sd256 : -16'sd256;
                nsa_pkg::KindSoftsgn:
                    val_reg <= neg_reg ? -16'(quot_reg) : 16'(quot_reg);
                nsa_pkg::KindRelu: begin
                    if (neg_reg) begin
                        val_reg <= 16'sd0;
                    end else if (x_reg > (PW-12)'(32767)) begin
                        val_reg <= 16'sd32767;
                        sat_reg <= 1'b1;
                    end else begin
                        val_reg <= x_reg[15:0];
                    end
                end
                default: val_reg <= 16'sd0;
            endcase
        end
    end

    assign m_activation_value = val_reg;
    assign m_saturated        = sat_reg;

endmodule

@@ sv/neuron_sum_activation_core.sv @@
// Neuron activation unit: sums input_count Q8.8 samples (one per cycle while
// accumulating), multiplies by the Q4.12 gain in a registered multiplier,
// rounds, and applies the selected activation. After the last accepted sample
// a group passes through multiply, round, select and output; softsign adds
// a bit-serial restoring divider between round and select. No sample is taken
// while a result is being formed or waits on m_ready.
module neuron_sum_activation_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_activation_value,
    output logic               m_saturated
);

    nsa_pkg::cmd_t  cmd;
    nsa_pkg::stat_t stat;

    nsa_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .stat, .cmd
    );

    nsa_datapath u_dp (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data, .s_sample, .cmd, .stat,
        .m_activation_value, .m_saturated
    );

endmodule
